// ===== hdl/bitvector_rank_then_set_top_defines.svh =====
// assertion macros for the rank-then-set block
`ifndef BITVECTOR_RANK_THEN_SET_TOP_DEFINES_SVH
`define BITVECTOR_RANK_THEN_SET_TOP_DEFINES_SVH

// checked only outside reset
`define BRS_ASSERT(lbl, ck, rs, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) prop) else $error(msg);

// checked on every edge, reset included
`define BRS_ASSERT_ALWAYS(lbl, ck, prop, msg) \
  lbl: assert property (@(posedge ck) prop) else $error(msg);

`endif

// ===== hdl/brs_pkg.sv =====
// shared types, constants and the popcount function of the rank-then-set block
package brs_pkg;

  localparam int NUM_WORDS_DEFAULT = 1024;
  localparam int WORD_W            = 64;
  localparam int BYTE_W            = 8;
  localparam int BYTES_PER_WORD    = WORD_W / BYTE_W;
  localparam int BIT_IDX_W         = 6;
  localparam int POS_W             = 16;
  localparam int WORD_IDX_W        = POS_W - BIT_IDX_W;
  localparam int MAX_WORDS         = 2 ** WORD_IDX_W;
  localparam int CMP_W             = WORD_IDX_W + 1;
  localparam int RANK_W            = 16;
  localparam int COUNT_W           = 17;
  localparam int POPC_W            = 7;
  localparam int BYTE_POPC_W       = 4;
  localparam logic [RANK_W-1:0] RANK_MAX = '1;

  typedef struct packed {
    logic [POS_W-1:0] position;
    logic             last_in_batch;
  } brs_in_t;

  typedef struct packed {
    logic [RANK_W-1:0] rank;
    logic              order_error;
  } brs_out_t;

  typedef struct packed {
    logic clr_en;
    logic load_in;
    logic walk_rd;
    logic walk_acc;
    logic tgt_rd;
    logic tgt_wr;
    logic finish;
  } brs_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic is_err;
    logic walk_done;
    logic in_store;
    logic out_free;
  } brs_status_t;

  // byte counts first, then a short sum over the eight bytes
  function automatic logic [POPC_W-1:0] popcount64(input logic [WORD_W-1:0] x);
    logic [BYTE_POPC_W-1:0] byte_cnt [BYTES_PER_WORD];
    logic [POPC_W-1:0]      total;
    for (int b = 0; b < BYTES_PER_WORD; b++) begin
      byte_cnt[b] = '0;
      for (int i = 0; i < BYTE_W; i++) begin
        byte_cnt[b] = byte_cnt[b] + BYTE_POPC_W'(x[b*BYTE_W+i]);
      end
    end
    total = '0;
    for (int b = 0; b < BYTES_PER_WORD; b++) begin
      total = total + POPC_W'(byte_cnt[b]);
    end
    return total;
  endfunction

endpackage

// ===== hdl/brs_ctrl.sv =====
// controller state machine of the rank-then-set block
module brs_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  brs_pkg::brs_status_t status,
  output brs_pkg::brs_cmd_t    cmd
);
  import brs_pkg::*;

  localparam logic [2:0] S_CLEAR    = 3'd0;
  localparam logic [2:0] S_IDLE     = 3'd1;
  localparam logic [2:0] S_CHECK    = 3'd2;
  localparam logic [2:0] S_WALK_RD  = 3'd3;
  localparam logic [2:0] S_WALK_ACC = 3'd4;
  localparam logic [2:0] S_TGT_RD   = 3'd5;
  localparam logic [2:0] S_TGT_CNT  = 3'd6;
  localparam logic [2:0] S_FINISH   = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_CLEAR: begin
        cmd.clr_en = 1'b1;
        if (status.clear_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_CHECK;
        end
      end
      S_CHECK: begin
        if (status.is_err) begin
          state_next = S_FINISH;
        end else if (status.walk_done) begin
          state_next = status.in_store ? S_TGT_RD : S_FINISH;
        end else begin
          state_next = S_WALK_RD;
        end
      end
      S_WALK_RD: begin
        cmd.walk_rd = 1'b1;
        state_next  = S_WALK_ACC;
      end
      S_WALK_ACC: begin
        cmd.walk_acc = 1'b1;
        state_next   = S_CHECK;
      end
      S_TGT_RD: begin
        cmd.tgt_rd = 1'b1;
        state_next = S_TGT_CNT;
      end
      S_TGT_CNT: begin
        cmd.tgt_wr = 1'b1;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        // hold until the output register is free
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign in_ready = (state == S_IDLE);

endmodule

// ===== hdl/brs_datapath.sv =====
// bit store, walk registers and result register of the rank-then-set block
module brs_datapath #(
  parameter int NUM_WORDS = brs_pkg::NUM_WORDS_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  brs_pkg::brs_in_t     in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output brs_pkg::brs_out_t    out_data,
  input  brs_pkg::brs_cmd_t    cmd,
  output brs_pkg::brs_status_t status
);
  import brs_pkg::*;

  // positions only reach MAX_WORDS words, so deeper stores are never addressed
  localparam int MEM_DEPTH = (NUM_WORDS < MAX_WORDS) ? NUM_WORDS : MAX_WORDS;
  localparam int PTR_W     = $clog2(MEM_DEPTH + 1);
  localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

  logic [WORD_W-1:0]     mem [MEM_DEPTH];
  logic [WORD_W-1:0]     rdata;
  logic [POS_W-1:0]      pos;
  logic                  last;
  logic [PTR_W-1:0]      ptr;
  logic [COUNT_W-1:0]    count;
  logic [POPC_W-1:0]     low_cnt;
  logic [PTR_W-1:0]      clr_cnt;

  logic [WORD_IDX_W-1:0] word;
  logic [BIT_IDX_W-1:0]  bit_sel;
  logic [CMP_W-1:0]      word_cmp;
  logic [CMP_W-1:0]      ptr_cmp;
  logic [CMP_W-1:0]      limit;
  logic [WORD_W-1:0]     one_hot;
  logic                  mem_we;
  logic                  mem_re;
  logic [ADDR_W-1:0]     waddr;
  logic [ADDR_W-1:0]     raddr;
  logic [WORD_W-1:0]     wdata;
  logic [COUNT_W-1:0]    rank_sum;
  logic [RANK_W-1:0]     rank_sat;

  assign word     = pos[POS_W-1:BIT_IDX_W];
  assign bit_sel  = pos[BIT_IDX_W-1:0];
  assign word_cmp = CMP_W'(word);
  assign ptr_cmp  = CMP_W'(ptr);
  assign one_hot  = WORD_W'(1) << bit_sel;

  assign status.in_store   = word_cmp < CMP_W'(MEM_DEPTH);
  assign limit             = status.in_store ? word_cmp : CMP_W'(MEM_DEPTH);
  assign status.is_err     = word_cmp < ptr_cmp;
  assign status.walk_done  = ptr_cmp == limit;
  assign status.clear_last = clr_cnt == PTR_W'(MEM_DEPTH - 1);
  assign status.out_free   = !out_valid || out_ready;

  assign mem_we = cmd.clr_en || cmd.tgt_wr;
  assign mem_re = cmd.walk_rd || cmd.tgt_rd;
  assign waddr  = cmd.clr_en ? clr_cnt[ADDR_W-1:0] : word[ADDR_W-1:0];
  assign raddr  = cmd.walk_rd ? ptr[ADDR_W-1:0] : word[ADDR_W-1:0];
  assign wdata  = cmd.clr_en ? '0 : (rdata | one_hot);

  always_ff @(posedge clk) begin
    if (mem_we) mem[waddr] <= wdata;
    if (mem_re) rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clr_en && !status.clear_last) begin
      clr_cnt <= clr_cnt + PTR_W'(1);
    end
  end

  // request payload and the count of low bits in the target word
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      pos     <= in_data.position;
      last    <= in_data.last_in_batch;
      low_cnt <= '0;
    end else if (cmd.tgt_wr) begin
      low_cnt <= popcount64(rdata & (one_hot - WORD_W'(1)));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr   <= '0;
      count <= '0;
    end else if (cmd.finish && last) begin
      ptr   <= '0;
      count <= '0;
    end else if (cmd.walk_acc) begin
      ptr   <= ptr + PTR_W'(1);
      count <= count + COUNT_W'(popcount64(rdata));
    end
  end

  assign rank_sum = count + COUNT_W'(low_cnt);
  assign rank_sat = (rank_sum > COUNT_W'(RANK_MAX)) ? RANK_MAX : rank_sum[RANK_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_data.order_error <= status.is_err;
      out_data.rank        <= status.is_err ? '0 : rank_sat;
    end
  end

endmodule

// ===== hdl/bitvector_rank_then_set_top.sv =====
// sequence: after accept, each stored word below the target word not yet counted is read
//   and its popcount added, one word at a time through the single read port of the store;
//   a target in the store is then read and written back with its bit set; a flagged request
//   skips to the result, and no new request is accepted until that result is registered
// reset: clears the walk state, then a clearing pass over min(NUM_WORDS, 1024)
//   words zeroes the bit store while in_ready stays low
module bitvector_rank_then_set_top #(
  parameter int NUM_WORDS = brs_pkg::NUM_WORDS_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  brs_pkg::brs_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output brs_pkg::brs_out_t out_data
);
  import brs_pkg::*;

  brs_cmd_t    cmd;
  brs_status_t status;

  brs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  brs_datapath #(
    .NUM_WORDS (NUM_WORDS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

// ===== hdl/brs_checker.sv =====
// port-level assertions of the rank-then-set block and their bind
`include "bitvector_rank_then_set_top_defines.svh"

module brs_checker (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input brs_pkg::brs_in_t  in_data,
  input logic              out_valid,
  input logic              out_ready,
  input brs_pkg::brs_out_t out_data
);
  import brs_pkg::*;

  logic in_seen;
  logic err_out;
  logic out_stall;
  assign in_seen   = in_valid && (in_data.position == in_data.position);
  assign err_out   = out_valid && out_data.order_error;
  assign out_stall = out_valid && !out_ready;

  // clearing pass follows reset, no request taken meanwhile
  `BRS_ASSERT_ALWAYS(a_clear_after_rst, clk, rst |=> !in_ready, "request taken during clear")

  // one request in flight at a time
  `BRS_ASSERT(a_one_in_flight, clk, rst, (in_seen && in_ready) |=> !in_ready, "ready after accept")

  // a flagged request reports zero rank
  `BRS_ASSERT(a_err_rank_zero, clk, rst, err_out |-> (out_data.rank == '0), "rank not zero")

  // stalled result holds
  `BRS_ASSERT(a_out_hold, clk, rst, out_stall |=> (out_valid && $stable(out_data)), "result moved")

endmodule

bind bitvector_rank_then_set_top brs_checker u_brs_checker (.*);
